[src/mwn_pkg.sv]
// Package: shared types, constants and tables for the mesh winding-number core.
`timescale 1ns / 1ps
package mwn_pkg;

   localparam int DIFF_W  = 17;
   localparam int OPA_W   = 18;
   localparam int OPB_W   = 37;
   localparam int PROD_W  = 55;
   localparam int ACC_W   = 56;
   localparam int SS_W    = 34;
   localparam int NRM_W   = 17;
   localparam int ANG_W   = 20;
   localparam int SUM_W   = 40;
   localparam int THR_W   = 39;
   localparam int FC_W    = 15;
   localparam int CRD_W   = 58;
   localparam int CORDIC_STEPS = 17;

   localparam logic [1:0] CMD_LOAD_VERTEX = 2'd0;
   localparam logic [1:0] CMD_LOAD_FACE   = 2'd1;
   localparam logic [1:0] CMD_QUERY       = 2'd2;
   localparam logic [1:0] CMD_RESERVED    = 2'd3;

   localparam logic CSR_FACE_COUNT = 1'b0;
   localparam logic CSR_THRESHOLD  = 1'b1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 39'd411775;
   localparam logic signed [ANG_W-1:0] PI_Q16 = 20'sd205887;
   localparam logic [SS_W-1:0] SQ_TOP_BIT = 34'h1_0000_0000;

   localparam logic [4:0] MOP_PHASE1_LAST = 5'd26;
   localparam logic [4:0] MOP_LAST        = 5'd31;
   localparam logic [1:0] NORM_COUNT      = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [13:0]        slot;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic [12:0]        corner_a;
      logic [12:0]        corner_b;
      logic [12:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic                    inside_res;
      logic signed [SUM_W-1:0] winding_sum;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_FACE_RD, ST_VTX_RD, ST_MAC1,
      ST_NORM_WAIT, ST_MAC2, ST_DEN_WAIT, ST_ATAN
   } state_type;

   typedef enum logic [3:0] {
      OPA_A0, OPA_A1, OPA_A2, OPA_B0, OPA_B1, OPA_B2, OPA_C0, OPA_C1, OPA_C2,
      OPA_NA, OPA_NB, OPA_NC
   } opa_type;

   typedef enum logic [4:0] {
      OPB_A0, OPB_A1, OPB_A2, OPB_B0, OPB_B1, OPB_B2, OPB_C0, OPB_C1, OPB_C2,
      OPB_BC0, OPB_BC1, OPB_BC2, OPB_NA, OPB_NB, OPB_NC,
      OPB_DAB, OPB_DBC, OPB_DCA, OPB_T
   } opb_type;

   typedef enum logic [3:0] {
      DST_SSA, DST_SSB, DST_SSC, DST_BC0, DST_BC1, DST_BC2, DST_NUM,
      DST_DAB, DST_DBC, DST_DCA, DST_T, DST_DEN
   } dest_type;

   typedef struct packed {
      opa_type  opa;
      opb_type  opb;
      logic     neg;
      logic     first;
      logic     last;
      dest_type dest;
   } mop_type;

   typedef struct packed {
      logic     valid;
      logic     neg;
      logic     first;
      logic     last;
      dest_type dest;
   } mac_ctl_type;

   typedef struct packed {
      logic                    valid;
      dest_type                dest;
      logic signed [ACC_W-1:0] value;
   } mac_wb_type;

   // Multiply-accumulate program for one face.
   function automatic mop_type mop_lookup(input logic [4:0] idx);
      mop_type m;
      m = '{OPA_A0, OPB_A0, 1'b0, 1'b0, 1'b0, DST_SSA};
      unique case (idx)
         5'd0:  m = '{OPA_A0, OPB_A0, 1'b0, 1'b1, 1'b0, DST_SSA};
         5'd1:  m = '{OPA_A1, OPB_A1, 1'b0, 1'b0, 1'b0, DST_SSA};
         5'd2:  m = '{OPA_A2, OPB_A2, 1'b0, 1'b0, 1'b1, DST_SSA};
         5'd3:  m = '{OPA_B0, OPB_B0, 1'b0, 1'b1, 1'b0, DST_SSB};
         5'd4:  m = '{OPA_B1, OPB_B1, 1'b0, 1'b0, 1'b0, DST_SSB};
         5'd5:  m = '{OPA_B2, OPB_B2, 1'b0, 1'b0, 1'b1, DST_SSB};
         5'd6:  m = '{OPA_C0, OPB_C0, 1'b0, 1'b1, 1'b0, DST_SSC};
         5'd7:  m = '{OPA_C1, OPB_C1, 1'b0, 1'b0, 1'b0, DST_SSC};
         5'd8:  m = '{OPA_C2, OPB_C2, 1'b0, 1'b0, 1'b1, DST_SSC};
         5'd9:  m = '{OPA_B1, OPB_C2, 1'b0, 1'b1, 1'b0, DST_BC0};
         5'd10: m = '{OPA_B2, OPB_C1, 1'b1, 1'b0, 1'b1, DST_BC0};
         5'd11: m = '{OPA_B2, OPB_C0, 1'b0, 1'b1, 1'b0, DST_BC1};
         5'd12: m = '{OPA_B0, OPB_C2, 1'b1, 1'b0, 1'b1, DST_BC1};
         5'd13: m = '{OPA_B0, OPB_C1, 1'b0, 1'b1, 1'b0, DST_BC2};
         5'd14: m = '{OPA_B1, OPB_C0, 1'b1, 1'b0, 1'b1, DST_BC2};
         5'd15: m = '{OPA_A0, OPB_BC0, 1'b0, 1'b1, 1'b0, DST_NUM};
         5'd16: m = '{OPA_A1, OPB_BC1, 1'b0, 1'b0, 1'b0, DST_NUM};
         5'd17: m = '{OPA_A2, OPB_BC2, 1'b0, 1'b0, 1'b1, DST_NUM};
         5'd18: m = '{OPA_A0, OPB_B0, 1'b0, 1'b1, 1'b0, DST_DAB};
         5'd19: m = '{OPA_A1, OPB_B1, 1'b0, 1'b0, 1'b0, DST_DAB};
         5'd20: m = '{OPA_A2, OPB_B2, 1'b0, 1'b0, 1'b1, DST_DAB};
         5'd21: m = '{OPA_B0, OPB_C0, 1'b0, 1'b1, 1'b0, DST_DBC};
         5'd22: m = '{OPA_B1, OPB_C1, 1'b0, 1'b0, 1'b0, DST_DBC};
         5'd23: m = '{OPA_B2, OPB_C2, 1'b0, 1'b0, 1'b1, DST_DBC};
         5'd24: m = '{OPA_C0, OPB_A0, 1'b0, 1'b1, 1'b0, DST_DCA};
         5'd25: m = '{OPA_C1, OPB_A1, 1'b0, 1'b0, 1'b0, DST_DCA};
         5'd26: m = '{OPA_C2, OPB_A2, 1'b0, 1'b0, 1'b1, DST_DCA};
         5'd27: m = '{OPA_NA, OPB_NB, 1'b0, 1'b1, 1'b1, DST_T};
         5'd28: m = '{OPA_NC, OPB_DAB, 1'b0, 1'b1, 1'b0, DST_DEN};
         5'd29: m = '{OPA_NA, OPB_DBC, 1'b0, 1'b0, 1'b0, DST_DEN};
         5'd30: m = '{OPA_NB, OPB_DCA, 1'b0, 1'b0, 1'b0, DST_DEN};
         5'd31: m = '{OPA_NC, OPB_T, 1'b0, 1'b0, 1'b1, DST_DEN};
      endcase
      return m;
   endfunction

   function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [4:0] i);
      logic signed [ANG_W-1:0] t;
      unique case (i)
         5'd0:  t = 20'sd51472;
         5'd1:  t = 20'sd30386;
         5'd2:  t = 20'sd16055;
         5'd3:  t = 20'sd8150;
         5'd4:  t = 20'sd4091;
         5'd5:  t = 20'sd2047;
         5'd6:  t = 20'sd1024;
         5'd7:  t = 20'sd512;
         5'd8:  t = 20'sd256;
         5'd9:  t = 20'sd128;
         5'd10: t = 20'sd64;
         5'd11: t = 20'sd32;
         5'd12: t = 20'sd16;
         5'd13: t = 20'sd8;
         5'd14: t = 20'sd4;
         5'd15: t = 20'sd2;
         5'd16: t = 20'sd1;
         default: t = 20'sd0;
      endcase
      return t;
   endfunction

endpackage

[src/mwn_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulate.
`timescale 1ns / 1ps
module mwn_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mwn_pkg::mac_ctl_type                ctl,
   input  logic signed [mwn_pkg::OPA_W-1:0]    opa,
   input  logic signed [mwn_pkg::OPB_W-1:0]    opb,
   output mwn_pkg::mac_wb_type                 wb,
   output logic                                mac_busy
);
   import mwn_pkg::*;

   mac_ctl_type               ctl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   term;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(opa * opb);
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      term   = ctl_ff.neg ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
      acc_in = (ctl_ff.first ? '0 : acc_ff) + term;
   end

   assign wb.valid  = ctl_ff.valid & ctl_ff.last;
   assign wb.dest   = ctl_ff.dest;
   assign wb.value  = acc_in;
   assign mac_busy  = ctl_ff.valid;
endmodule

[src/mwn_sqrt.sv]
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module mwn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sq_start,
   input  logic [mwn_pkg::SS_W-1:0]      sq_value,
   output logic                          sq_busy,
   output logic                          sq_done,
   output logic [mwn_pkg::NRM_W-1:0]     sq_root
);
   import mwn_pkg::*;

   logic            busy_ff, busy_in, done_ff, done_in;
   logic [SS_W-1:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in, trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (sq_start) begin
         busy_in = 1'b1;
         n_in    = sq_value;
         res_in  = '0;
         bit_in  = SQ_TOP_BIT;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign sq_busy = busy_ff;
   assign sq_done = done_ff;
   assign sq_root = res_ff[NRM_W-1:0];
endmodule

[src/mwn_cordic.sv]
// Vectoring CORDIC for atan2, one micro-rotation per cycle.
`timescale 1ns / 1ps
module mwn_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cr_start,
   input  logic signed [mwn_pkg::ACC_W-1:0]    cr_y,
   input  logic signed [mwn_pkg::ACC_W-1:0]    cr_x,
   output logic                                cr_done,
   output logic signed [mwn_pkg::ANG_W-1:0]    cr_angle
);
   import mwn_pkg::*;

   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [4:0]              i_ff, i_in;
   logic signed [CRD_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, x0, y0;
   logic signed [ANG_W-1:0] z_ff, z_in, t;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      i_in    = i_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      x0      = CRD_W'(cr_x);
      y0      = CRD_W'(cr_y);
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      t       = atan_lookup(i_ff);
      if (cr_start) begin
         i_in = '0;
         if (cr_x == '0 && cr_y == '0) begin
            // Degenerate face: the term is zero.
            z_in    = '0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            if (cr_x < 0) begin
               x_in = -x0;
               y_in = -y0;
               z_in = (cr_y >= 0) ? PI_Q16 : -PI_Q16;
            end else begin
               x_in = x0;
               y_in = y0;
               z_in = '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff < 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - t;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + t;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign cr_done  = done_ff;
   assign cr_angle = z_ff;
endmodule

[src/mesh_winding_number_inside_test_core.sv]
// Top level: mesh stores, face sequencer and the shared arithmetic units.
`timescale 1ns / 1ps
//
//  Channel   Ports                             Transfer
//  --------  --------------------------------  -------------------------------
//  request   start, busy, req_data             start high while busy is low
//  result    rsp_valid, rsp_data               rsp_valid high for one cycle
//  config    csr_we, csr_index, csr_wdata      csr_we high at a clock edge
//
// A load-vertex or load-face transfer is written into its store at the edge
// that accepts it and busy never rises for it. A query keeps busy high while
// it reads each face in use and its three corners, runs the first multiply
// pass and the three bit-serial square roots that run one after another,
// forms the last products, starts the CORDIC and runs its 17 steps. A
// degenerate face skips the CORDIC steps. The result strobe is high in the
// first cycle after busy falls.
// Reset is synchronous and active high; both stores hold no reset value and
// must be loaded before a query reads them. The receiver cannot stall, so a
// result is driven for exactly one cycle and nothing waits on it.
module mesh_winding_number_inside_test_core #(
   parameter int VERTEX_DEPTH = 8192,
   parameter int FACE_DEPTH   = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  mwn_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output mwn_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [mwn_pkg::THR_W-1:0]     csr_wdata
);
   import mwn_pkg::*;

   localparam int VAW   = $clog2(VERTEX_DEPTH);
   localparam int FAW   = $clog2(FACE_DEPTH);
   localparam int CNT_W = (FAW + 1 > FC_W) ? FAW + 1 : FC_W;

   // Configuration registers.
   logic [FC_W-1:0]  face_count_ff;
   logic [THR_W-1:0] threshold_ff;

   // Mesh stores.
   logic [47:0] vmem [VERTEX_DEPTH];
   logic [38:0] fmem [FACE_DEPTH];
   logic [47:0] vtx_q_ff;
   logic [38:0] face_q_ff;

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fidx_ff, fidx_in, fc_eff;
   logic [1:0]       vcnt_ff, vcnt_in;
   logic [4:0]       opc_ff, opc_in;
   logic [1:0]       nidx_ff, nidx_in;
   logic [2:0]       ssv_ff, ssv_in;
   logic             corner_ok_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-query and per-face data.
   logic signed [15:0]       p_ff [3];
   logic signed [DIFF_W-1:0] diff_ff [9];
   logic [SS_W-1:0]          ss_ff [3];
   logic [NRM_W-1:0]         nrm_ff [3];
   logic signed [OPB_W-1:0]  bc_ff [3];
   logic signed [OPB_W-1:0]  dab_ff, dbc_ff, dca_ff, t_ff;
   logic signed [ACC_W-1:0]  num_ff, den_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   rsp_type                  rsp_ff;

   // Control decoded from the state.
   logic        accept, face_rd, vtx_rd, capture, face_begin, sum_clear;
   logic [12:0] corner_sel;
   logic        corner_ok;

   // Shared unit connections.
   mop_type                 mop;
   mac_ctl_type             mac_ctl;
   mac_wb_type              wb;
   logic                    mac_busy;
   logic signed [OPA_W-1:0] opa_val;
   logic signed [OPB_W-1:0] opb_val;
   logic                    sq_start, sq_busy, sq_done, sq_ready;
   logic [SS_W-1:0]         sq_value;
   logic [NRM_W-1:0]        sq_root;
   logic                    cr_start, cr_done;
   logic signed [ANG_W-1:0] cr_angle;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign fc_eff = (CNT_W'(face_count_ff) > CNT_W'(FACE_DEPTH)) ?
                   CNT_W'(FACE_DEPTH) : CNT_W'(face_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         face_count_ff <= '0;
         threshold_ff  <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FACE_COUNT: face_count_ff <= csr_wdata[FC_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata;
         endcase
      end
   end

   // Loads are written straight from the accepted transfer; an out-of-range
   // slot is dropped.
   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_LOAD_VERTEX && 32'(req_data.slot) < VERTEX_DEPTH)
      begin
         vmem[VAW'(req_data.slot)] <= {req_data.coord_x, req_data.coord_y,
                                       req_data.coord_z};
      end
      if (vtx_rd) begin
         vtx_q_ff <= vmem[VAW'(corner_sel)];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_LOAD_FACE && 32'(req_data.slot) < FACE_DEPTH)
      begin
         fmem[FAW'(req_data.slot)] <= {req_data.corner_a, req_data.corner_b,
                                       req_data.corner_c};
      end
      if (face_rd) begin
         face_q_ff <= fmem[fidx_ff[FAW-1:0]];
      end
   end

   // Corner picked for the vertex read in this cycle.
   always_comb begin
      unique case (vcnt_ff)
         2'd0:    corner_sel = face_q_ff[38:26];
         2'd1:    corner_sel = face_q_ff[25:13];
         default: corner_sel = face_q_ff[12:0];
      endcase
      corner_ok = (32'(corner_sel) < VERTEX_DEPTH);
   end

   // Sequencer: next state and the strobes it drives.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fidx_ff      <= '0;
         vcnt_ff      <= '0;
         opc_ff       <= '0;
         nidx_ff      <= '0;
         ssv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fidx_ff      <= fidx_in;
         vcnt_ff      <= vcnt_in;
         opc_ff       <= opc_in;
         nidx_ff      <= nidx_in;
         ssv_ff       <= ssv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fidx_in      = fidx_ff;
      vcnt_in      = vcnt_ff;
      opc_in       = opc_ff;
      nidx_in      = nidx_ff;
      ssv_in       = ssv_ff;
      rsp_valid_in = 1'b0;
      face_rd      = 1'b0;
      vtx_rd       = 1'b0;
      capture      = 1'b0;
      face_begin   = 1'b0;
      sum_clear    = 1'b0;
      mac_ctl      = '0;
      cr_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_QUERY) begin
               sum_clear = 1'b1;
               fidx_in   = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fidx_ff == fc_eff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_FACE_RD;
            end
         end
         ST_FACE_RD: begin
            face_rd    = 1'b1;
            face_begin = 1'b1;
            vcnt_in    = '0;
            nidx_in    = '0;
            ssv_in     = '0;
            state_in   = ST_VTX_RD;
         end
         ST_VTX_RD: begin
            // Reads go out for corners a, b, c; each lands in the cycle after it goes out.
            vtx_rd  = (vcnt_ff != 2'd3);
            capture = (vcnt_ff != 2'd0);
            vcnt_in = vcnt_ff + 2'd1;
            if (vcnt_ff == 2'd3) begin
               opc_in   = '0;
               state_in = ST_MAC1;
            end
         end
         ST_MAC1: begin
            mac_ctl = '{1'b1, mop.neg, mop.first, mop.last, mop.dest};
            opc_in  = opc_ff + 5'd1;
            if (opc_ff == MOP_PHASE1_LAST) begin
               state_in = ST_NORM_WAIT;
            end
         end
         ST_NORM_WAIT: begin
            if (nidx_ff == NORM_COUNT && !mac_busy) begin
               state_in = ST_MAC2;
            end
         end
         ST_MAC2: begin
            mac_ctl = '{1'b1, mop.neg, mop.first, mop.last, mop.dest};
            opc_in  = opc_ff + 5'd1;
            if (opc_ff == MOP_LAST) begin
               state_in = ST_DEN_WAIT;
            end
         end
         ST_DEN_WAIT: begin
            if (!mac_busy) begin
               cr_start = 1'b1;
               state_in = ST_ATAN;
            end
         end
         ST_ATAN: begin
            if (cr_done) begin
               fidx_in  = fidx_ff + CNT_W'(1);
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Sum-of-squares results mark their norm as ready to start.
      if (wb.valid) begin
         unique case (wb.dest)
            DST_SSA: ssv_in[0] = 1'b1;
            DST_SSB: ssv_in[1] = 1'b1;
            DST_SSC: ssv_in[2] = 1'b1;
            default: ;
         endcase
      end
      if (sq_done) begin
         nidx_in = nidx_ff + 2'd1;
      end
   end

   // The square root unit takes the norms of A, B and C in turn.
   always_comb begin
      unique case (nidx_ff)
         2'd0:    begin sq_ready = ssv_ff[0]; sq_value = ss_ff[0]; end
         2'd1:    begin sq_ready = ssv_ff[1]; sq_value = ss_ff[1]; end
         2'd2:    begin sq_ready = ssv_ff[2]; sq_value = ss_ff[2]; end
         default: begin sq_ready = 1'b0;      sq_value = ss_ff[0]; end
      endcase
      sq_start = sq_ready && !sq_busy && !sq_done && !face_begin;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_QUERY) begin
         p_ff[0] <= req_data.coord_x;
         p_ff[1] <= req_data.coord_y;
         p_ff[2] <= req_data.coord_z;
      end
      corner_ok_ff <= corner_ok;
      if (capture) begin
         // Corners shift in so that A ends in the low three places.
         for (int k = 0; k < 6; k++) begin
            diff_ff[k] <= diff_ff[k+3];
         end
         diff_ff[6] <= DIFF_W'(corner_ok_ff ? $signed(vtx_q_ff[47:32]) : 16'sd0) -
                       DIFF_W'(p_ff[0]);
         diff_ff[7] <= DIFF_W'(corner_ok_ff ? $signed(vtx_q_ff[31:16]) : 16'sd0) -
                       DIFF_W'(p_ff[1]);
         diff_ff[8] <= DIFF_W'(corner_ok_ff ? $signed(vtx_q_ff[15:0]) : 16'sd0) -
                       DIFF_W'(p_ff[2]);
      end
      if (wb.valid) begin
         unique case (wb.dest)
            DST_SSA: ss_ff[0] <= wb.value[SS_W-1:0];
            DST_SSB: ss_ff[1] <= wb.value[SS_W-1:0];
            DST_SSC: ss_ff[2] <= wb.value[SS_W-1:0];
            DST_BC0: bc_ff[0] <= wb.value[OPB_W-1:0];
            DST_BC1: bc_ff[1] <= wb.value[OPB_W-1:0];
            DST_BC2: bc_ff[2] <= wb.value[OPB_W-1:0];
            DST_NUM: num_ff   <= wb.value;
            DST_DAB: dab_ff   <= wb.value[OPB_W-1:0];
            DST_DBC: dbc_ff   <= wb.value[OPB_W-1:0];
            DST_DCA: dca_ff   <= wb.value[OPB_W-1:0];
            DST_T:   t_ff     <= wb.value[OPB_W-1:0];
            DST_DEN: den_ff   <= wb.value;
         endcase
      end
      if (sq_done) begin
         unique case (nidx_ff)
            2'd0:    nrm_ff[0] <= sq_root;
            2'd1:    nrm_ff[1] <= sq_root;
            default: nrm_ff[2] <= sq_root;
         endcase
      end
      sum_ff <= sum_in;
      rsp_ff <= '{($signed(sum_ff) > $signed({1'b0, threshold_ff})), sum_ff};
   end

   always_comb begin
      sum_in = sum_ff;
      if (sum_clear) begin
         sum_in = '0;
      end else if (state_ff == ST_ATAN && cr_done) begin
         sum_in = sum_ff + SUM_W'(cr_angle);
      end
   end

   // Operand selection for the shared multiplier.
   assign mop = mop_lookup(opc_ff);

   always_comb begin
      unique case (mop.opa)
         OPA_A0: opa_val = OPA_W'(diff_ff[0]);
         OPA_A1: opa_val = OPA_W'(diff_ff[1]);
         OPA_A2: opa_val = OPA_W'(diff_ff[2]);
         OPA_B0: opa_val = OPA_W'(diff_ff[3]);
         OPA_B1: opa_val = OPA_W'(diff_ff[4]);
         OPA_B2: opa_val = OPA_W'(diff_ff[5]);
         OPA_C0: opa_val = OPA_W'(diff_ff[6]);
         OPA_C1: opa_val = OPA_W'(diff_ff[7]);
         OPA_C2: opa_val = OPA_W'(diff_ff[8]);
         OPA_NA: opa_val = $signed({1'b0, nrm_ff[0]});
         OPA_NB: opa_val = $signed({1'b0, nrm_ff[1]});
         OPA_NC: opa_val = $signed({1'b0, nrm_ff[2]});
         default: opa_val = '0;
      endcase
      unique case (mop.opb)
         OPB_A0:  opb_val = OPB_W'(diff_ff[0]);
         OPB_A1:  opb_val = OPB_W'(diff_ff[1]);
         OPB_A2:  opb_val = OPB_W'(diff_ff[2]);
         OPB_B0:  opb_val = OPB_W'(diff_ff[3]);
         OPB_B1:  opb_val = OPB_W'(diff_ff[4]);
         OPB_B2:  opb_val = OPB_W'(diff_ff[5]);
         OPB_C0:  opb_val = OPB_W'(diff_ff[6]);
         OPB_C1:  opb_val = OPB_W'(diff_ff[7]);
         OPB_C2:  opb_val = OPB_W'(diff_ff[8]);
         OPB_BC0: opb_val = bc_ff[0];
         OPB_BC1: opb_val = bc_ff[1];
         OPB_BC2: opb_val = bc_ff[2];
         OPB_NA:  opb_val = $signed({20'd0, nrm_ff[0]});
         OPB_NB:  opb_val = $signed({20'd0, nrm_ff[1]});
         OPB_NC:  opb_val = $signed({20'd0, nrm_ff[2]});
         OPB_DAB: opb_val = dab_ff;
         OPB_DBC: opb_val = dbc_ff;
         OPB_DCA: opb_val = dca_ff;
         OPB_T:   opb_val = t_ff;
         default: opb_val = '0;
      endcase
   end

   mwn_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .opa      (opa_val),
      .opb      (opb_val),
      .wb       (wb),
      .mac_busy (mac_busy)
   );

   mwn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sq_start (sq_start),
      .sq_value (sq_value),
      .sq_busy  (sq_busy),
      .sq_done  (sq_done),
      .sq_root  (sq_root)
   );

   mwn_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .cr_start (cr_start),
      .cr_y     (num_ff),
      .cr_x     (den_ff),
      .cr_done  (cr_done),
      .cr_angle (cr_angle)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
